@@ rtl/core/dcsl_pkg.sv @@
// shared types and constants for the dmx channel smoothed level core
// no dependencies; imported by the core and the checker

package dcsl_pkg;

	localparam int DEF_HISTORY_DEPTH = 16;

	localparam int IDX_W = 9;
	localparam int VAL_W = 8;
	localparam int WIN_W = 5;
	localparam int SUM_W = VAL_W + WIN_W;
	localparam int REM_W = WIN_W + 1;
	localparam int STEP_W = 4;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int IN_W = 24;

	typedef enum logic [1:0] {
		REG_CHANNEL   = 2'd0,
		REG_THRESHOLD = 2'd1,
		REG_WINDOW    = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_READ = 2'd1,
		ST_DIV  = 2'd2,
		ST_DONE = 2'd3
	} state_t;

endpackage

@@ rtl/core/dmx_channel_smoothed_level_core.sv @@
// dmx channel smoothed level core: captures one slot into a history ring and emits
// its floored moving average; depends on dcsl_pkg and dcsl_ram

// An item whose slot index differs from the channel register is taken and gives no
// result. An item on the channel is written into the history ring and its modulator
// level then enters the output register, n being the smoothing window (at least one):
// the history ram is read one entry per cycle for n entries, a bit-serial divider
// divides their sum by n and the level is loaded. The block is not ready from the
// capture until the level is loaded, and the load waits while an earlier level is
// still stalled at the output; a finished level waits in its output register while
// the next item is taken. History entries never captured read as zero through
// per-entry valid bits cleared at reset, so no clearing pass is needed. Registers:
// channel at 0x0, threshold at 0x4, smoothing window at 0x8; a window write whose
// low five bits exceed the history depth is dropped.

module dmx_channel_smoothed_level_core
	import dcsl_pkg::*;
#(
	parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_W-1:0]   s_axis_tdata,  // slot_index [8:0], slot_value [16:9]
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [VAL_W-1:0]  m_axis_tdata,  // modulator [7:0]
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_POS = AW'(HISTORY_DEPTH - 1);
	localparam logic [IDX_W-1:0] DEPTH_LIM = IDX_W'(HISTORY_DEPTH);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

	state_t state_q, state_d;

	logic [IDX_W-1:0] channel_q;
	logic [VAL_W-1:0] threshold_q;
	logic [WIN_W-1:0] window_q;
	logic [AW-1:0] pos_q, new_pos, rd_ptr_q;
	logic [WIN_W-1:0] issued_q, count_n;
	logic rd_s1, vld_s1;
	logic [SUM_W-1:0] sum_q;
	logic [REM_W-1:0] rem_q, rem_sh, divisor;
	logic [STEP_W-1:0] step_q;
	logic [HISTORY_DEPTH-1:0] valid_q;
	logic out_valid_q;
	logic [VAL_W-1:0] out_data_q, level;
	logic [VAL_W-1:0] rdata;

	logic [IDX_W-1:0] slot_index;
	logic [VAL_W-1:0] slot_value;
	logic in_acc, hit, cfg_wr, rd_en, div_en, load_out, read_done, div_last, q_bit;
	reg_idx_t reg_sel;

	assign slot_index = s_axis_tdata[IDX_W-1:0];
	assign slot_value = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign hit = in_acc && (slot_index == channel_q);
	assign new_pos = (pos_q == '0) ? LAST_POS : pos_q - AW'(1);
	assign count_n = (window_q == '0) ? WIN_W'(1) : window_q;
	assign divisor = {1'b0, count_n};
	assign read_done = (issued_q == count_n) && !rd_s1;
	assign div_last = (step_q == LAST_STEP);
	assign rem_sh = {rem_q[REM_W-2:0], sum_q[SUM_W-1]};
	assign q_bit = (rem_sh >= divisor);
	assign level = (sum_q[VAL_W-1:0] < threshold_q) ? threshold_q : sum_q[VAL_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (hit) state_d = ST_READ;
			ST_READ: if (read_done) state_d = ST_DIV;
			ST_DIV:  if (div_last) state_d = ST_DONE;
			ST_DONE: if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		rd_en = 1'b0;
		div_en = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_READ: rd_en = (issued_q != count_n);
			ST_DIV:  div_en = 1'b1;
			ST_DONE: load_out = !out_valid_q || m_axis_tready;
			default: s_axis_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= '0;
			threshold_q <= '0;
			window_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_CHANNEL:   channel_q <= pwdata[IDX_W-1:0];
				REG_THRESHOLD: threshold_q <= pwdata[VAL_W-1:0];
				REG_WINDOW: begin
					if ({{(IDX_W-WIN_W){1'b0}}, pwdata[WIN_W-1:0]} <= DEPTH_LIM) begin
						window_q <= pwdata[WIN_W-1:0];
					end
				end
				REG_NONE: ;
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_CHANNEL:   prdata = DATA_W'(channel_q);
			REG_THRESHOLD: prdata = DATA_W'(threshold_q);
			REG_WINDOW:    prdata = DATA_W'(window_q);
			REG_NONE:      prdata = '0;
			default:       prdata = '0;
		endcase
	end

	// history ring control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= LAST_POS;
			valid_q <= '0;
			rd_s1 <= 1'b0;
			issued_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= rd_en;
			if (hit) begin
				pos_q <= new_pos;
				valid_q[new_pos] <= 1'b1;
				issued_q <= '0;
			end else if (rd_en) begin
				issued_q <= issued_q + WIN_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// read pointer, accumulator and divider datapath
	always_ff @(posedge clk) begin
		vld_s1 <= valid_q[rd_ptr_q];
		if (hit) begin
			rd_ptr_q <= new_pos;
			sum_q <= '0;
		end else begin
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_POS) ? '0 : rd_ptr_q + AW'(1);
			end
			if (rd_s1) begin
				sum_q <= sum_q + (vld_s1 ? SUM_W'(rdata) : '0);
			end else if (div_en) begin
				sum_q <= {sum_q[SUM_W-2:0], q_bit};
			end
		end
		if (state_q == ST_READ) begin
			rem_q <= '0;
			step_q <= '0;
		end else if (div_en) begin
			rem_q <= q_bit ? rem_sh - divisor : rem_sh;
			step_q <= step_q + STEP_W'(1);
		end
		if (load_out) begin
			out_data_q <= level;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	dcsl_ram #(
		.WIDTH(VAL_W),
		.DEPTH(HISTORY_DEPTH),
		.AW(AW)
	) u_history (
		.clk(clk),
		.we(hit),
		.waddr(new_pos),
		.wdata(slot_value),
		.re(rd_en),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

endmodule

@@ rtl/core/dcsl_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies

module dcsl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/dcsl_checker.sv @@
// port-level checks for dmx_channel_smoothed_level_core, bound to the top level
// depends on dcsl_pkg

module dcsl_checker
	import dcsl_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic [IN_W-1:0]   s_axis_tdata,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [VAL_W-1:0]  m_axis_tdata,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	input logic [DATA_W-1:0] prdata,
	input logic              pready
);

	logic [VAL_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& reg_idx_t'(paddr[ADDR_W-1:2]) == REG_THRESHOLD) begin
			thr_q <= pwdata[VAL_W-1:0];
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata >= thr_q)
		else $error("level below threshold");

	a_busy_before_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result item without a busy capture");

endmodule

bind dmx_channel_smoothed_level_core dcsl_checker u_dcsl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata(s_axis_tdata),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.paddr(paddr),
	.pwdata(pwdata),
	.prdata(prdata),
	.pready(pready)
);
